### rtl/bad_pkg.sv
// ----------------------------------------------------------------------------
// bad_pkg
// shared types, constants and lookup tables of the box average downscaler
// ----------------------------------------------------------------------------
`default_nettype none

package bad_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int MAX_SHRINK  = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam int ADDR_W  = $clog2(MAX_WIDTH);     // line buffer index
    localparam int COL_W   = $clog2(MAX_WIDTH);     // source column counter
    localparam int ROW_W   = $clog2(MAX_HEIGHT);    // source row counter
    localparam int DIM_W   = 13;                    // width / height registers
    localparam int FAC_W   = 5;                     // factor register
    localparam int PHASE_W = 4;                     // phase inside a square
    localparam int SUM_W   = 16;                    // partial block sum
    localparam int AREA_W  = 9;                     // factor squared
    localparam int RW_W    = 14;                    // width reciprocal
    localparam int RA_W    = 17;                    // area reciprocal
    localparam int RW_SH   = 13;                    // width reciprocal scale
    localparam int RA_SH   = 16;                    // area reciprocal scale
    localparam int APB_AW  = 4;
    localparam int APB_DW  = 32;

    typedef enum logic [1:0] {
        REG_SHRINK = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_idx_t;

    // settled configuration handed to front and back
    typedef struct packed {
        logic                settled;
        logic [FAC_W-1:0]    factor;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [DIM_W-1:0]    out_w;
        logic [DIM_W-1:0]    out_wf;
        logic [DIM_W-1:0]    out_hf;
        logic [AREA_W-1:0]   area;
        logic [RA_W-1:0]     area_recip;
    } cfg_t;

    // one accumulate command for the back end
    typedef struct packed {
        logic [7:0]          pix;
        logic [ADDR_W-1:0]   addr;
        logic                first;
        logic                close;
        logic                row_end;
        logic                frame_end;
    } cmd_t;

    // floor(2^13 / f), f in 1..16
    function automatic logic [RW_W-1:0] width_recip(input logic [FAC_W-1:0] f);
        logic [RW_W-1:0] r;
        case (f)
            5'd1:    r = 14'd8192;
            5'd2:    r = 14'd4096;
            5'd3:    r = 14'd2730;
            5'd4:    r = 14'd2048;
            5'd5:    r = 14'd1638;
            5'd6:    r = 14'd1365;
            5'd7:    r = 14'd1170;
            5'd8:    r = 14'd1024;
            5'd9:    r = 14'd910;
            5'd10:   r = 14'd819;
            5'd11:   r = 14'd744;
            5'd12:   r = 14'd682;
            5'd13:   r = 14'd630;
            5'd14:   r = 14'd585;
            5'd15:   r = 14'd546;
            5'd16:   r = 14'd512;
            default: r = 14'd8192;
        endcase
        return r;
    endfunction

    // floor(2^16 / f^2), f in 1..16
    function automatic logic [RA_W-1:0] area_recip(input logic [FAC_W-1:0] f);
        logic [RA_W-1:0] r;
        case (f)
            5'd1:    r = 17'd65536;
            5'd2:    r = 17'd16384;
            5'd3:    r = 17'd7281;
            5'd4:    r = 17'd4096;
            5'd5:    r = 17'd2621;
            5'd6:    r = 17'd1820;
            5'd7:    r = 17'd1337;
            5'd8:    r = 17'd1024;
            5'd9:    r = 17'd809;
            5'd10:   r = 17'd655;
            5'd11:   r = 17'd541;
            5'd12:   r = 17'd455;
            5'd13:   r = 17'd387;
            5'd14:   r = 17'd334;
            5'd15:   r = 17'd291;
            5'd16:   r = 17'd256;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/bad_stream_if.sv
// ----------------------------------------------------------------------------
// bad_pix_if / bad_avg_if
// valid/ready channels for source pixels and averaged pixels
// ----------------------------------------------------------------------------
`default_nettype none

interface bad_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;
    logic       frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface bad_avg_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_out;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);
endinterface

`default_nettype wire

### rtl/bad_cfg.sv
// ----------------------------------------------------------------------------
// bad_cfg
// apb register file, clamping and derived output geometry
// ----------------------------------------------------------------------------
`default_nettype none

module bad_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bad_pkg::APB_AW-1:0] paddr,
    input  logic [bad_pkg::APB_DW-1:0] pwdata,
    output logic [bad_pkg::APB_DW-1:0] prdata,
    output bad_pkg::cfg_t             cfg
);
    import bad_pkg::*;

    localparam int HOLD_CYCLES = 3;
    localparam int HOLD_W      = $clog2(HOLD_CYCLES + 1);
    localparam int PW_W        = DIM_W + RW_SH;
    localparam int MUL_W       = DIM_W + FAC_W;

    logic [FAC_W-1:0]  shrink_reg;
    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [HOLD_W-1:0] hold_reg;
    logic [HOLD_W-1:0] hold_next;
    logic              wr_en;
    reg_idx_t          idx;

    // derive stage 1
    logic [FAC_W-1:0]  f1_reg, f1_next;
    logic [DIM_W-1:0]  w1_reg, w1_next;
    logic [DIM_W-1:0]  h1_reg, h1_next;
    logic [PW_W-1:0]   pw1_reg, ph1_reg;
    logic [AREA_W-1:0] area1_reg;
    logic [RA_W-1:0]   ra1_reg;
    // derive stage 2
    logic [FAC_W-1:0]  f2_reg;
    logic [DIM_W-1:0]  w2_reg, h2_reg;
    logic [DIM_W-1:0]  qw2_reg, qh2_reg;
    logic [DIM_W-1:0]  mw2_reg, mh2_reg;
    logic [AREA_W-1:0] area2_reg;
    logic [RA_W-1:0]   ra2_reg;
    logic [DIM_W-1:0]  qw_est, qh_est;
    logic [MUL_W-1:0]  mw_full, mh_full;
    // derive stage 3
    logic [DIM_W-1:0]  outw_next, outwf_next, outhf_next;
    logic [DIM_W-1:0]  rem_w, rem_h;
    cfg_t              cfg_reg;

    assign idx   = reg_idx_t'(paddr[3:2]);
    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shrink_reg <= FAC_W'(1);
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
        end
        else if (wr_en)
        begin
            case (idx)
                REG_SHRINK: shrink_reg <= pwdata[FAC_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SHRINK: prdata = APB_DW'(shrink_reg);
            REG_WIDTH:  prdata = APB_DW'(width_reg);
            REG_HEIGHT: prdata = APB_DW'(height_reg);
            default:    prdata = '0;
        endcase
    end

    // hold off input while the derived values settle
    always_comb
    begin
        if (wr_en)
            hold_next = HOLD_W'(HOLD_CYCLES);
        else if (hold_reg != '0)
            hold_next = hold_reg - HOLD_W'(1);
        else
            hold_next = hold_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= HOLD_W'(HOLD_CYCLES);
        else
            hold_reg <= hold_next;
    end

    // stage 1: clamp, reciprocal multiply
    always_comb
    begin
        if (shrink_reg == '0)
            f1_next = FAC_W'(1);
        else if (shrink_reg > FAC_W'(MAX_SHRINK))
            f1_next = FAC_W'(MAX_SHRINK);
        else
            f1_next = shrink_reg;

        if (width_reg == '0)
            w1_next = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_WIDTH))
            w1_next = DIM_W'(MAX_WIDTH);
        else
            w1_next = width_reg;

        if (height_reg == '0)
            h1_next = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_HEIGHT))
            h1_next = DIM_W'(MAX_HEIGHT);
        else
            h1_next = height_reg;
    end

    always_ff @(posedge clk)
    begin
        f1_reg    <= f1_next;
        w1_reg    <= w1_next;
        h1_reg    <= h1_next;
        pw1_reg   <= PW_W'(w1_next) * PW_W'(width_recip(f1_next));
        ph1_reg   <= PW_W'(h1_next) * PW_W'(width_recip(f1_next));
        area1_reg <= AREA_W'(f1_next) * AREA_W'(f1_next);
        ra1_reg   <= area_recip(f1_next);
    end

    // stage 2: quotient estimate times factor
    assign qw_est  = pw1_reg[PW_W-1:RW_SH];
    assign qh_est  = ph1_reg[PW_W-1:RW_SH];
    assign mw_full = MUL_W'(qw_est) * MUL_W'(f1_reg);
    assign mh_full = MUL_W'(qh_est) * MUL_W'(f1_reg);

    always_ff @(posedge clk)
    begin
        f2_reg    <= f1_reg;
        w2_reg    <= w1_reg;
        h2_reg    <= h1_reg;
        qw2_reg   <= qw_est;
        qh2_reg   <= qh_est;
        mw2_reg   <= mw_full[DIM_W-1:0];
        mh2_reg   <= mh_full[DIM_W-1:0];
        area2_reg <= area1_reg;
        ra2_reg   <= ra1_reg;
    end

    // stage 3: estimate is low by at most one
    always_comb
    begin
        rem_w = w2_reg - mw2_reg;
        rem_h = h2_reg - mh2_reg;
        if (rem_w >= DIM_W'(f2_reg))
        begin
            outw_next  = qw2_reg + DIM_W'(1);
            outwf_next = mw2_reg + DIM_W'(f2_reg);
        end
        else
        begin
            outw_next  = qw2_reg;
            outwf_next = mw2_reg;
        end
        if (rem_h >= DIM_W'(f2_reg))
            outhf_next = mh2_reg + DIM_W'(f2_reg);
        else
            outhf_next = mh2_reg;
    end

    // settled rises on the edge where the hold count reaches zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
        begin
            cfg_reg.settled    <= (hold_next == '0);
            cfg_reg.factor     <= f2_reg;
            cfg_reg.width      <= w2_reg;
            cfg_reg.height     <= h2_reg;
            cfg_reg.out_w      <= outw_next;
            cfg_reg.out_wf     <= outwf_next;
            cfg_reg.out_hf     <= outhf_next;
            cfg_reg.area       <= area2_reg;
            cfg_reg.area_recip <= ra2_reg;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

### rtl/bad_front.sv
// ----------------------------------------------------------------------------
// bad_front
// source position tracking and square classification
// ----------------------------------------------------------------------------
`default_nettype none

module bad_front (
    input  logic          clk,
    input  logic          rst_n,
    input  bad_pkg::cfg_t cfg,
    bad_pix_if.sink       pixel_stream,
    input  logic          q_full,
    output logic          push,
    output bad_pkg::cmd_t push_cmd
);
    import bad_pkg::*;

    logic [COL_W-1:0]   col_reg, col_next, cur_col;
    logic [ROW_W-1:0]   row_reg, row_next, cur_row;
    logic [PHASE_W-1:0] cp_reg, cp_next, cur_cp;
    logic [PHASE_W-1:0] rp_reg, rp_next, cur_rp;
    logic [ADDR_W-1:0]  oc_reg, oc_next, cur_oc;
    logic               accept;
    logic               in_square;
    logic [FAC_W-1:0]   f_last;
    logic [DIM_W-1:0]   col_inc, row_inc;
    logic [FAC_W-1:0]   cp_inc, rp_inc;

    assign pixel_stream.ready = cfg.settled && !q_full;
    assign accept             = pixel_stream.valid && pixel_stream.ready;

    always_comb
    begin
        if (pixel_stream.frame_start)
        begin
            cur_col = '0;
            cur_row = '0;
            cur_cp  = '0;
            cur_rp  = '0;
            cur_oc  = '0;
        end
        else
        begin
            cur_col = col_reg;
            cur_row = row_reg;
            cur_cp  = cp_reg;
            cur_rp  = rp_reg;
            cur_oc  = oc_reg;
        end
    end

    // classify
    always_comb
    begin
        f_last    = cfg.factor - FAC_W'(1);
        in_square = (DIM_W'(cur_col) < cfg.out_wf) && (DIM_W'(cur_row) < cfg.out_hf)
                 && (DIM_W'(cur_oc) < cfg.out_w);
        push_cmd.pix       = pixel_stream.pixel_in;
        push_cmd.addr      = cur_oc;
        push_cmd.first     = (cur_rp == '0) && (cur_cp == '0);
        push_cmd.close     = (FAC_W'(cur_rp) == f_last) && (FAC_W'(cur_cp) == f_last);
        push_cmd.row_end   = (DIM_W'(cur_oc) == cfg.out_w - DIM_W'(1));
        push_cmd.frame_end = push_cmd.row_end
                          && (DIM_W'(cur_row) == cfg.out_hf - DIM_W'(1));
        push               = accept && in_square;
    end

    // advance
    always_comb
    begin
        col_inc  = DIM_W'(cur_col) + DIM_W'(1);
        row_inc  = DIM_W'(cur_row) + DIM_W'(1);
        cp_inc   = FAC_W'(cur_cp) + FAC_W'(1);
        rp_inc   = FAC_W'(cur_rp) + FAC_W'(1);
        col_next = cur_col;
        row_next = cur_row;
        cp_next  = cur_cp;
        rp_next  = cur_rp;
        oc_next  = cur_oc;
        if (col_inc >= cfg.width)
        begin
            col_next = '0;
            cp_next  = '0;
            oc_next  = '0;
            if (row_inc >= cfg.height)
            begin
                row_next = '0;
                rp_next  = '0;
            end
            else
            begin
                row_next = row_inc[ROW_W-1:0];
                rp_next  = (rp_inc >= cfg.factor) ? '0 : rp_inc[PHASE_W-1:0];
            end
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            if (cp_inc >= cfg.factor)
            begin
                cp_next = '0;
                oc_next = cur_oc + ADDR_W'(1);
            end
            else
                cp_next = cp_inc[PHASE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cp_reg  <= '0;
            rp_reg  <= '0;
            oc_reg  <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cp_reg  <= cp_next;
            rp_reg  <= rp_next;
            oc_reg  <= oc_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bad_fifo.sv
// ----------------------------------------------------------------------------
// bad_fifo
// short command queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module bad_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  bad_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          head_valid,
    output bad_pkg::cmd_t head_cmd
);
    import bad_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slots_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/bad_back.sv
// ----------------------------------------------------------------------------
// bad_back
// line buffer accumulate and divide-by-area pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module bad_back (
    input  logic          clk,
    input  logic          rst_n,
    input  bad_pkg::cfg_t cfg,
    input  logic          head_valid,
    input  bad_pkg::cmd_t head_cmd,
    output logic          pop,
    bad_avg_if.source     average_stream
);
    import bad_pkg::*;

    localparam int PROD_W = SUM_W + RA_W;
    localparam int QF_W   = SUM_W + AREA_W;

    logic [SUM_W-1:0] sums_mem [MAX_WIDTH];

    // accumulate stage
    logic             s1_valid_reg;
    cmd_t             s1_cmd_reg;
    logic [SUM_W-1:0] rd_data_reg;
    logic             fwd_hit_reg;
    logic [SUM_W-1:0] fwd_data_reg;
    logic [SUM_W-1:0] s1_base, s1_sum;
    logic             s1_fire;

    // multiply stages
    logic              s2_valid_reg;
    logic [PROD_W-1:0] s2_prod_reg;
    logic [SUM_W-1:0]  s2_sum_reg;
    logic              s2_row_end_reg, s2_frame_end_reg;
    logic              s3_valid_reg;
    logic [SUM_W-1:0]  s3_q_reg;
    logic [QF_W-1:0]   s3_qf_reg;
    logic [SUM_W-1:0]  s3_sum_reg;
    logic              s3_row_end_reg, s3_frame_end_reg;
    logic [SUM_W-1:0]  s2_q;
    logic [SUM_W-1:0]  rem;
    logic [SUM_W-1:0]  q_next;

    // result register
    logic              out_valid_reg;
    logic [7:0]        out_pix_reg;
    logic              out_row_end_reg, out_frame_end_reg;

    logic              out_take, s3_ready, s2_ready;

    assign out_take = !out_valid_reg || average_stream.ready;
    assign s3_ready = !s3_valid_reg || out_take;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_fire  = s1_valid_reg && (!s1_cmd_reg.close || s2_ready);
    assign pop      = head_valid && (!s1_valid_reg || s1_fire);

    // same-edge write is not seen by the read, so it is forwarded
    assign s1_base = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign s1_sum  = s1_cmd_reg.first ? SUM_W'(s1_cmd_reg.pix)
                                      : s1_base + SUM_W'(s1_cmd_reg.pix);

    always_ff @(posedge clk)
    begin
        if (pop)
            rd_data_reg <= sums_mem[head_cmd.addr];
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
            sums_mem[s1_cmd_reg.addr] <= s1_sum;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_cmd_reg   <= head_cmd;
            fwd_hit_reg  <= s1_fire && (s1_cmd_reg.addr == head_cmd.addr);
            fwd_data_reg <= s1_sum;
        end
    end

    // sum times reciprocal of area
    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_cmd_reg.close)
        begin
            s2_prod_reg      <= PROD_W'(s1_sum) * PROD_W'(cfg.area_recip);
            s2_sum_reg       <= s1_sum;
            s2_row_end_reg   <= s1_cmd_reg.row_end;
            s2_frame_end_reg <= s1_cmd_reg.frame_end;
        end
    end

    // estimate times area for the remainder check
    assign s2_q = s2_prod_reg[RA_SH+SUM_W-1:RA_SH];

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_q_reg         <= s2_q;
            s3_qf_reg        <= QF_W'(s2_q) * QF_W'(cfg.area);
            s3_sum_reg       <= s2_sum_reg;
            s3_row_end_reg   <= s2_row_end_reg;
            s3_frame_end_reg <= s2_frame_end_reg;
        end
    end

    // estimate is low by at most one
    always_comb
    begin
        rem    = s3_sum_reg - s3_qf_reg[SUM_W-1:0];
        q_next = (rem >= SUM_W'(cfg.area)) ? s3_q_reg + SUM_W'(1) : s3_q_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_take)
        begin
            out_pix_reg       <= q_next[7:0];
            out_row_end_reg   <= s3_row_end_reg;
            out_frame_end_reg <= s3_frame_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_fire)
                s1_valid_reg <= 1'b0;

            if (s1_fire && s1_cmd_reg.close)
                s2_valid_reg <= 1'b1;
            else if (s3_ready)
                s2_valid_reg <= 1'b0;

            if (s2_valid_reg && s3_ready)
                s3_valid_reg <= 1'b1;
            else if (out_take)
                s3_valid_reg <= 1'b0;

            if (s3_valid_reg && out_take)
                out_valid_reg <= 1'b1;
            else if (average_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign average_stream.valid     = out_valid_reg;
    assign average_stream.pixel_out = out_pix_reg;
    assign average_stream.row_end   = out_row_end_reg;
    assign average_stream.frame_end = out_frame_end_reg;

endmodule

`default_nettype wire

### rtl/box_average_downscaler.sv
// ----------------------------------------------------------------------------
// box_average_downscaler
// integer-factor box filter downsampler for 8-bit grey raster video
// ----------------------------------------------------------------------------
//
//  channel         dir  handshake            payload
//  pixel_stream    in   valid/ready          pixel_in[7:0], frame_start
//  average_stream  out  valid/ready          pixel_out[7:0], row_end, frame_end
//  apb             in   psel/penable/pready  paddr[3:0], pwdata, prdata
//
//  one source pixel beat per cycle sustained while the queue has room; a result
//  beat leaves once the beat that closes its square has passed the queue,
//  accumulate, two multiply stages and the result register
//  after reset, and after every register write, the input is held off
//  while the output geometry is derived from the registers
//  a stalled output fills the divide pipeline and then the four-entry queue;
//  only then does the input see ready low
//
// ----------------------------------------------------------------------------
`default_nettype none

module box_average_downscaler (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [bad_pkg::APB_AW-1:0] paddr,
    input  logic [bad_pkg::APB_DW-1:0] pwdata,
    output logic [bad_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    bad_pix_if.sink                    pixel_stream,
    bad_avg_if.source                  average_stream
);
    import bad_pkg::*;

    cfg_t cfg;        // clamped and derived settings
    logic q_push;     // front found a pixel inside a whole square
    cmd_t q_push_cmd;
    logic q_full;
    logic q_pop;
    logic q_head_valid;
    cmd_t q_head_cmd;

    // register writes take effect without wait states
    assign pready = 1'b1;

    // registers plus divider-free derivation of output width and height
    bad_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // position counters: every beat is taken, only beats in a whole square
    // are queued, the rest are dropped here
    bad_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pixel_stream (pixel_stream),
        .q_full       (q_full),
        .push         (q_push),
        .push_cmd     (q_push_cmd)
    );

    // decouples the front from output backpressure
    bad_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // column sum read-modify-write, then floor divide by factor squared
    bad_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .head_valid     (q_head_valid),
        .head_cmd       (q_head_cmd),
        .pop            (q_pop),
        .average_stream (average_stream)
    );

endmodule

`default_nettype wire
